>>> rtl/tsff_pkg.sv
package tsff_pkg;

	// frames in one flash pattern
	localparam int unsigned PATTERN_LENGTH = 100;
	localparam int unsigned IDX_W = $clog2(PATTERN_LENGTH);

	localparam logic [7:0] COUNT_MAX = 8'hFF;
	localparam logic [7:0] LIMIT_RESET = 8'd5;

	// configuration register map
	localparam int unsigned PADDR_W = 3;
	localparam logic REG_AUTO_FLASH_LIMIT = 1'b0;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_HAZARD,
		MODE_RIGHT,
		MODE_LEFT
	} mode_t;

	// one frame tick as captured from the input channel
	typedef struct packed {
		logic hazard_switch;
		logic right_switch;
		logic left_switch;
		logic illumination;
		logic position_enable;
	} frame_in_t;

	// one result item
	typedef struct packed {
		logic       fade_enable;
		logic       right_lamp;
		logic       left_lamp;
		logic       right_position;
		logic       left_position;
		logic [6:0] duty;
		mode_t      mode;
	} frame_out_t;

	// fade ramp, duty in percent
	localparam logic [6:0] FADE_TAB [PATTERN_LENGTH] = '{
		7'd100, 7'd98, 7'd96, 7'd94, 7'd91, 7'd89, 7'd87, 7'd85, 7'd83, 7'd81,
		7'd79, 7'd77, 7'd75, 7'd74, 7'd72, 7'd70, 7'd68, 7'd66, 7'd65, 7'd63,
		7'd61, 7'd60, 7'd58, 7'd56, 7'd55, 7'd53, 7'd52, 7'd50, 7'd49, 7'd47,
		7'd46, 7'd44, 7'd43, 7'd41, 7'd40, 7'd39, 7'd37, 7'd36, 7'd35, 7'd34,
		7'd33, 7'd31, 7'd30, 7'd29, 7'd28, 7'd27, 7'd26, 7'd25, 7'd24, 7'd23,
		7'd22, 7'd21, 7'd20, 7'd19, 7'd18, 7'd17, 7'd16, 7'd16, 7'd15, 7'd14,
		7'd13, 7'd13, 7'd12, 7'd11, 7'd11, 7'd10, 7'd9, 7'd9, 7'd8, 7'd8,
		7'd7, 7'd7, 7'd6, 7'd6, 7'd5, 7'd5, 7'd4, 7'd4, 7'd4, 7'd3,
		7'd3, 7'd3, 7'd2, 7'd2, 7'd2, 7'd2, 7'd1, 7'd1, 7'd1, 7'd1,
		7'd1, 7'd1, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0
	};

	// on/off pattern for the first hazard cycle
	localparam logic [6:0] BLINK_TAB [PATTERN_LENGTH] = '{
		7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100,
		7'd100, 7'd100, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
		7'd0, 7'd0, 7'd0, 7'd0, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100,
		7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd0, 7'd0, 7'd0, 7'd0,
		7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd100, 7'd100,
		7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100,
		7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
		7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
		7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
		7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0
	};

	// table reads, out of range reads as zero
	function automatic logic [6:0] fade_lookup(input logic [IDX_W-1:0] idx);
		logic [6:0] val;
		val = 7'd0;
		if (32'(idx) < PATTERN_LENGTH) begin
			val = FADE_TAB[idx];
		end
		return val;
	endfunction

	function automatic logic [6:0] blink_lookup(input logic [IDX_W-1:0] idx);
		logic [6:0] val;
		val = 7'd0;
		if (32'(idx) < PATTERN_LENGTH) begin
			val = BLINK_TAB[idx];
		end
		return val;
	endfunction

endpackage

>>> rtl/turn_signal_fade_flasher_top.sv
// a result passes the input register, then the result register, before it is valid
// one frame per cycle unless stalled; pattern state updates in the single step stage
// a stalled result register holds while the input register can still take one frame
// reset: asynchronous, active low; idle mode, frame index, cycle count and duty cleared,
// auto_flash_limit set to 5, both channels empty
module turn_signal_fade_flasher_top import tsff_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               hazard_switch,
	input  logic               right_switch,
	input  logic               left_switch,
	input  logic               illumination,
	input  logic               position_enable,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               fade_enable,
	output logic               right_lamp,
	output logic               left_lamp,
	output logic               right_position,
	output logic               left_position,
	output logic [6:0]         duty,
	output logic [1:0]         mode,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic       valid_s1;
	frame_in_t  frame_s1;
	logic       valid_s2;
	frame_out_t result_s2;
	frame_out_t result;
	logic       advance;
	logic [7:0] auto_flash_limit;

	// step fires when a frame waits and the result register is empty or is being read out
	assign advance = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	tsff_apb u_apb (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.auto_flash_limit (auto_flash_limit)
	);

	tsff_step u_step (
		.clk              (clk),
		.arst_n           (arst_n),
		.step_en          (advance),
		.frame            (frame_s1),
		.auto_flash_limit (auto_flash_limit),
		.result           (result)
	);

	// input register valid and result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			frame_s1 <= '{
				hazard_switch:   hazard_switch,
				right_switch:    right_switch,
				left_switch:     left_switch,
				illumination:    illumination,
				position_enable: position_enable
			};
		end
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign fade_enable = result_s2.fade_enable;
	assign right_lamp = result_s2.right_lamp;
	assign left_lamp = result_s2.left_lamp;
	assign right_position = result_s2.right_position;
	assign left_position = result_s2.left_position;
	assign duty = result_s2.duty;
	assign mode = result_s2.mode;

endmodule

>>> rtl/tsff_apb.sv
module tsff_apb import tsff_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output logic [7:0]         auto_flash_limit
);

	logic [7:0] limit_q;
	logic       reg_hit;

	// word select, byte lanes inside a word ignored
	assign reg_hit = (paddr[PADDR_W-1:2] == REG_AUTO_FLASH_LIMIT);

	// register write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && reg_hit) begin
			limit_q <= pwdata[7:0];
		end
	end

	// read back
	always_comb begin
		prdata = 32'd0;
		if (reg_hit) begin
			prdata = {24'd0, limit_q};
		end
	end

	assign pready = 1'b1;
	assign auto_flash_limit = limit_q;

endmodule

>>> rtl/tsff_step.sv
module tsff_step import tsff_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step_en,
	input  frame_in_t  frame,
	input  logic [7:0] auto_flash_limit,
	output frame_out_t result
);

	mode_t            flash_mode_q;
	logic [IDX_W-1:0] frame_index_q;
	logic [7:0]       cycle_count_q;
	logic [6:0]       held_duty_q;

	mode_t            used;
	mode_t            flash_mode_d;
	logic [IDX_W-1:0] frame_index_d;
	logic [IDX_W-1:0] index_inc;
	logic [7:0]       cycle_count_d;
	logic [7:0]       count_inc;
	logic [6:0]       held_duty_d;
	logic             pos;
	logic             is_turn;

	assign pos = frame.illumination & frame.position_enable;
	assign count_inc = cycle_count_q + 8'd1;

	// mode pick when idle: hazard, then right, then left
	always_comb begin
		used = flash_mode_q;
		if (flash_mode_q == MODE_IDLE) begin
			if (frame.hazard_switch) begin
				used = MODE_HAZARD;
			end else if (frame.right_switch) begin
				used = MODE_RIGHT;
			end else if (frame.left_switch) begin
				used = MODE_LEFT;
			end
		end
	end

	assign is_turn = (used == MODE_RIGHT) || (used == MODE_LEFT);

	// lamps and duty for this frame
	always_comb begin
		result = '0;
		held_duty_d = held_duty_q;
		result.fade_enable = (used != MODE_IDLE);
		result.mode = used;
		case (used)
			MODE_IDLE: begin
				result.right_position = pos;
				result.left_position = pos;
			end
			MODE_HAZARD: begin
				result.right_lamp = 1'b1;
				result.left_lamp = 1'b1;
				held_duty_d = (cycle_count_q == 8'd0) ? blink_lookup(frame_index_q)
					: fade_lookup(frame_index_q);
			end
			MODE_RIGHT: begin
				result.right_lamp = 1'b1;
				result.left_position = pos;
				held_duty_d = fade_lookup(frame_index_q);
			end
			default: begin
				result.left_lamp = 1'b1;
				result.right_position = pos;
				held_duty_d = fade_lookup(frame_index_q);
			end
		endcase
		result.duty = held_duty_d;
	end

	// frame index, cycle count and pattern end
	always_comb begin
		flash_mode_d = used;
		cycle_count_d = cycle_count_q;
		if (used == MODE_IDLE) begin
			index_inc = IDX_W'(1);
			cycle_count_d = 8'd0;
		end else begin
			index_inc = frame_index_q + IDX_W'(1);
		end
		frame_index_d = index_inc;
		if (32'(index_inc) >= PATTERN_LENGTH) begin
			frame_index_d = '0;
			flash_mode_d = MODE_IDLE;
			if (cycle_count_q < COUNT_MAX) begin
				cycle_count_d = count_inc;
				if (is_turn && (count_inc < auto_flash_limit)) begin
					flash_mode_d = used;
				end
			end
		end
	end

	// pattern state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flash_mode_q <= MODE_IDLE;
			frame_index_q <= '0;
			cycle_count_q <= 8'd0;
			held_duty_q <= 7'd0;
		end else if (step_en) begin
			flash_mode_q <= flash_mode_d;
			frame_index_q <= frame_index_d;
			cycle_count_q <= cycle_count_d;
			held_duty_q <= held_duty_d;
		end
	end

endmodule
